// ===== rtl/glpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glpf_pkg: shared types and constants for the grid local peak finder
// Register indexes, the task control word passed from the front to the back,
// and modulo-3 helpers for the line store row rotation.
// ----------------------------------------------------------------------------
package glpf_pkg;

	localparam int CFG_W       = 6;
	localparam int COORD_W     = 5;
	localparam int QUEUE_DEPTH = 4;

	localparam logic REG_ROW_COUNT    = 1'b0;
	localparam logic REG_COLUMN_COUNT = 1'b1;

	// control part of one queued sample
	typedef struct packed {
		logic [1:0] rm3;        // row mod 3, line store row of this sample
		logic       row_first;  // sample sits in row 0
		logic       row_deep;   // sample row >= 2, so the decided cell has an upper neighbor
		logic       col_last;   // last column of the row
		logic       frame_last; // last sample of the frame
	} task_ctl_t;

	function automatic logic [1:0] mod3_inc(input logic [1:0] v);
		return (v == 2'd2) ? 2'd0 : v + 2'd1;
	endfunction

	function automatic logic [1:0] mod3_dec(input logic [1:0] v);
		return (v == 2'd0) ? 2'd2 : v - 2'd1;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/glpf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glpf_front: sample intake and position tracking
// Holds the frame size registers and the grid position, tags each accepted
// sample with its row, column and frame flags and pushes it to the queue.
// ----------------------------------------------------------------------------
module glpf_front import glpf_pkg::*; #(
	parameter int MAX_COLUMNS = 32,
	parameter int MAX_ROWS    = 32,
	parameter int SAMPLE_BITS = 16,
	localparam int COL_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic                   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data,
	input  wire logic                   s_valid,
	output logic                        s_ready,
	input  wire logic [SAMPLE_BITS-1:0] s_sample,
	output logic                        push_valid,
	input  wire logic                   push_ready,
	output task_ctl_t                   push_ctl,
	output logic [COORD_W-1:0]          push_row,
	output logic [COL_W-1:0]            push_col,
	output logic [SAMPLE_BITS-1:0]      push_sample,
	output logic [COL_W-1:0]            last_col
);

	localparam int COLS_CAP = (MAX_COLUMNS < 63) ? MAX_COLUMNS : 63;
	localparam int ROWS_CAP = (MAX_ROWS < 63) ? MAX_ROWS : 63;

	logic [CFG_W-1:0] row_count_q;
	logic [CFG_W-1:0] column_count_q;
	logic [CFG_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [1:0]       rm3_q;
	logic [CFG_W-1:0] last_row;
	logic             accept;
	logic             col_last;
	logic             frame_last;

	// zero acts as one, anything above the cap acts as the cap
	always_comb begin
		if (row_count_q == '0)
			last_row = '0;
		else if (int'(row_count_q) > ROWS_CAP)
			last_row = CFG_W'(ROWS_CAP - 1);
		else
			last_row = row_count_q - CFG_W'(1);

		if (column_count_q == '0)
			last_col = '0;
		else if (int'(column_count_q) > COLS_CAP)
			last_col = COL_W'(COLS_CAP - 1);
		else
			last_col = COL_W'(column_count_q - CFG_W'(1));
	end

	assign col_last   = (col_q == last_col);
	assign frame_last = col_last && (row_q == last_row);
	assign s_ready    = push_ready;
	assign accept     = s_valid && push_ready;

	assign push_valid          = s_valid;
	assign push_ctl.rm3        = rm3_q;
	assign push_ctl.row_first  = (row_q == '0);
	assign push_ctl.row_deep   = (row_q >= CFG_W'(2));
	assign push_ctl.col_last   = col_last;
	assign push_ctl.frame_last = frame_last;
	assign push_row            = row_q[COORD_W-1:0];
	assign push_col            = col_q;
	assign push_sample         = s_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= CFG_W'(1);
			column_count_q <= CFG_W'(1);
			row_q          <= '0;
			col_q          <= '0;
			rm3_q          <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_COUNT:    row_count_q    <= cfg_data;
				REG_COLUMN_COUNT: column_count_q <= cfg_data;
				default:          ;
			endcase
			// any write restarts the frame
			row_q <= '0;
			col_q <= '0;
			rm3_q <= '0;
		end else if (accept) begin
			if (frame_last) begin
				row_q <= '0;
				col_q <= '0;
				rm3_q <= '0;
			end else if (col_last) begin
				row_q <= row_q + CFG_W'(1);
				col_q <= '0;
				rm3_q <= mod3_inc(rm3_q);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/glpf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glpf_queue: small request queue between front and back
// Register-based FIFO; the head entry is presented without a read delay.
// ----------------------------------------------------------------------------
module glpf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/glpf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glpf_back: line store, neighbor window and peak decision
// Writes each sample into a three-row line store, reads the right and upper
// neighbors of the cell one row up, keeps the center and left cells in a
// sliding window, and scans the last row after the final sample of a frame.
// ----------------------------------------------------------------------------
module glpf_back import glpf_pkg::*; #(
	parameter int MAX_COLUMNS = 32,
	parameter int SAMPLE_BITS = 16,
	localparam int COL_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [COL_W-1:0]       last_col,
	input  wire logic                   pop_valid,
	output logic                        pop_ready,
	input  wire task_ctl_t              pop_ctl,
	input  wire logic [COORD_W-1:0]     pop_row,
	input  wire logic [COL_W-1:0]       pop_col,
	input  wire logic [SAMPLE_BITS-1:0] pop_sample,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [COORD_W-1:0]          out_row,
	output logic [COORD_W-1:0]          out_col,
	output logic                        out_peak,
	output logic                        out_end
);

	localparam logic signed [SAMPLE_BITS-1:0] ZERO = '0;

	typedef enum logic [1:0] {
		B_RUN,
		B_FL_RD,
		B_FL_EV,
		B_MARK
	} back_state_t;

	function automatic logic peak_f(
		input logic signed [SAMPLE_BITS-1:0] x,
		input logic signed [SAMPLE_BITS-1:0] up,
		input logic signed [SAMPLE_BITS-1:0] dn,
		input logic signed [SAMPLE_BITS-1:0] lf,
		input logic signed [SAMPLE_BITS-1:0] rt
	);
		return (x >= up) && (x >= dn) && (x >= lf) && (x >= rt);
	endfunction

	logic signed [SAMPLE_BITS-1:0] line_mem [3][MAX_COLUMNS];

	back_state_t                   state_q;
	logic [COL_W-1:0]              k_q;
	logic signed [SAMPLE_BITS-1:0] xwin_q;
	logic signed [SAMPLE_BITS-1:0] left_q;

	logic                          b_valid_q;
	task_ctl_t                     ctl_s1;
	logic [COORD_W-1:0]            row_s1;
	logic [COL_W-1:0]              col_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic                          fwd_s1;
	logic signed [SAMPLE_BITS-1:0] rd_a_s1;
	logic signed [SAMPLE_BITS-1:0] rd_b_s1;

	logic                          out_valid_q;
	logic [COORD_W-1:0]            out_row_q;
	logic [COORD_W-1:0]            out_col_q;
	logic                          out_peak_q;
	logic                          out_end_q;

	logic                          out_free;
	logic                          out_load;
	logic                          run_dec;
	logic                          fl_dec;
	logic                          b_retire;
	logic                          pop;
	logic                          rd_en;
	logic [1:0]                    a_row;
	logic [COL_W-1:0]              a_col;
	logic [1:0]                    b_row;
	logic [COL_W-1:0]              b_col;
	logic signed [SAMPLE_BITS-1:0] next_x;

	assign out_free = !out_valid_q || out_ready;

	// cell (r-1, c) decided against the new sample below it
	assign run_dec = !ctl_s1.row_first && peak_f(xwin_q,
		ctl_s1.row_deep ? rd_b_s1 : ZERO,
		smp_s1,
		(col_s1 == '0) ? ZERO : left_q,
		ctl_s1.col_last ? ZERO : rd_a_s1);

	// last row scan: nothing below
	assign fl_dec = peak_f(xwin_q,
		ctl_s1.row_first ? ZERO : rd_b_s1,
		ZERO,
		(k_q == '0) ? ZERO : left_q,
		(k_q == last_col) ? ZERO : rd_a_s1);

	assign b_retire  = (state_q == B_RUN) && b_valid_q && (!run_dec || out_free);
	assign pop       = (state_q == B_RUN) && pop_valid &&
		(!b_valid_q || (b_retire && !ctl_s1.frame_last));
	assign pop_ready = pop;
	assign rd_en     = pop || (state_q == B_FL_RD);

	assign out_load = (b_retire && run_dec) ||
		((state_q == B_FL_EV) && fl_dec && out_free) ||
		((state_q == B_MARK) && out_free);

	// at the end of a row port A fetches column 0 of the current row as the next center
	always_comb begin
		if (state_q == B_RUN) begin
			a_row = pop_ctl.col_last ? pop_ctl.rm3 : mod3_dec(pop_ctl.rm3);
			a_col = pop_ctl.col_last ? '0 : pop_col + COL_W'(1);
			b_row = mod3_dec(mod3_dec(pop_ctl.rm3));
			b_col = pop_col;
		end else begin
			a_row = ctl_s1.rm3;
			a_col = (k_q == last_col) ? '0 : k_q + COL_W'(1);
			b_row = mod3_dec(ctl_s1.rm3);
			b_col = k_q;
		end
	end

	// single column: the prefetch hits the cell written in the same cycle
	assign next_x = (ctl_s1.col_last && fwd_s1) ? smp_s1 : rd_a_s1;

	always_ff @(posedge clk) begin
		if (pop)
			line_mem[pop_ctl.rm3][pop_col] <= pop_sample;
		if (rd_en) begin
			rd_a_s1 <= line_mem[a_row][a_col];
			rd_b_s1 <= line_mem[b_row][b_col];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_RUN;
			k_q         <= '0;
			xwin_q      <= '0;
			left_q      <= '0;
			b_valid_q   <= 1'b0;
			ctl_s1      <= '0;
			row_s1      <= '0;
			col_s1      <= '0;
			smp_s1      <= '0;
			fwd_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_peak_q  <= 1'b0;
			out_end_q   <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				B_RUN: begin
					if (b_retire) begin
						left_q <= xwin_q;
						xwin_q <= next_x;
						if (run_dec) begin
							out_row_q  <= row_s1 - COORD_W'(1);
							out_col_q  <= COORD_W'(col_s1);
							out_peak_q <= 1'b1;
							out_end_q  <= 1'b0;
						end
						if (ctl_s1.frame_last) begin
							state_q <= B_FL_RD;
							k_q     <= '0;
						end
					end
					if (pop) begin
						b_valid_q <= 1'b1;
						ctl_s1    <= pop_ctl;
						row_s1    <= pop_row;
						col_s1    <= pop_col;
						smp_s1    <= pop_sample;
						fwd_s1    <= pop_ctl.col_last && (pop_col == '0);
					end else if (b_retire) begin
						b_valid_q <= 1'b0;
					end
				end
				B_FL_RD: begin
					state_q <= B_FL_EV;
				end
				B_FL_EV: begin
					if (!fl_dec || out_free) begin
						if (fl_dec) begin
							out_row_q  <= row_s1;
							out_col_q  <= COORD_W'(k_q);
							out_peak_q <= 1'b1;
							out_end_q  <= 1'b0;
						end
						left_q <= xwin_q;
						xwin_q <= rd_a_s1;
						if (k_q == last_col) begin
							state_q <= B_MARK;
						end else begin
							k_q     <= k_q + COL_W'(1);
							state_q <= B_FL_RD;
						end
					end
				end
				B_MARK: begin
					if (out_free) begin
						out_row_q  <= '0;
						out_col_q  <= '0;
						out_peak_q <= 1'b0;
						out_end_q  <= 1'b1;
						state_q    <= B_RUN;
					end
				end
				default: state_q <= B_RUN;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_peak  = out_peak_q;
	assign out_end   = out_end_q;

endmodule
`default_nettype wire

// ===== rtl/grid_local_peak_finder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_local_peak_finder_core: 4-neighbor local maximum detector
// Finds cells of a streamed row-major grid that are >= all four neighbors,
// with out-of-grid neighbors taken as zero, and reports their coordinates.
//
//  channel | dir | fields
//  --------+-----+---------------------------------------------------
//  cfg     | in  | cfg_we, cfg_index (0 row_count, 1 column_count), cfg_data
//  s_axis  | in  | tdata: sample
//  m_axis  | out | tdata: peak_row, peak_column; tuser: is_peak; tlast: frame_end
//
// One sample a cycle is accepted while the queue has room. A decided cell is
// reported via the queue, sample and output registers after the sample below it.
// After the final sample the back end scans the last row in the line store,
// reading then evaluating each column, then sends the end-of-frame marker;
// samples queue up meanwhile. Reset clears positions and sets both counts to 1.
// Output stalls hold the back end while the front fills the four-entry queue.
// ----------------------------------------------------------------------------
module grid_local_peak_finder_core import glpf_pkg::*; #(
	parameter int MAX_COLUMNS = 32,
	parameter int MAX_ROWS    = 32,
	parameter int SAMPLE_BITS = 16,
	localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [SAMPLE_BITS-1:0] sample
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [15:0]                m_tdata,   // [4:0] peak_row, [9:5] peak_column
	output logic                       m_tuser,   // is_peak
	output logic                       m_tlast    // frame_end
);

	localparam int COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int Q_W       = $bits(task_ctl_t) + COORD_W + COL_W + SAMPLE_BITS;

	task_ctl_t                push_ctl;
	logic [COORD_W-1:0]       push_row;
	logic [COL_W-1:0]         push_col;
	logic [SAMPLE_BITS-1:0]   push_sample;
	logic                     push_valid;
	logic                     push_ready;
	logic [Q_W-1:0]           push_data;

	task_ctl_t                pop_ctl;
	logic [COORD_W-1:0]       pop_row;
	logic [COL_W-1:0]         pop_col;
	logic [SAMPLE_BITS-1:0]   pop_sample;
	logic                     pop_valid;
	logic                     pop_ready;
	logic [Q_W-1:0]           pop_data;

	logic [COL_W-1:0]         last_col;
	logic [COORD_W-1:0]       out_row;
	logic [COORD_W-1:0]       out_col;

	glpf_front #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_valid     (s_tvalid),
		.s_ready     (s_tready),
		.s_sample    (s_tdata[SAMPLE_BITS-1:0]),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_ctl    (push_ctl),
		.push_row    (push_row),
		.push_col    (push_col),
		.push_sample (push_sample),
		.last_col    (last_col)
	);

	assign push_data = {push_ctl, push_row, push_col, push_sample};

	glpf_queue #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign {pop_ctl, pop_row, pop_col, pop_sample} = pop_data;

	glpf_back #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.last_col   (last_col),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_ctl    (pop_ctl),
		.pop_row    (pop_row),
		.pop_col    (pop_col),
		.pop_sample (pop_sample),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_peak   (m_tuser),
		.out_end    (m_tlast)
	);

	assign m_tdata = {6'b0, out_col, out_row};

endmodule
`default_nettype wire
